[rtl/sacc_pkg.sv]
// Shared types and constants for the set-associative cache controller.
package sacc_pkg;
  localparam int CostW = 16;
  localparam logic [CostW-1:0] CostMax = 16'hFFFF;
  localparam int MissUnit = 100;

  localparam logic [2:0] RegSetBits = 3'd0;
  localparam logic [2:0] RegWays = 3'd1;
  localparam logic [2:0] RegBlockBits = 3'd2;
  localparam logic [2:0] RegWriteAlloc = 3'd3;
  localparam logic [2:0] RegWriteBack = 3'd4;
  localparam logic [2:0] RegUseLru = 3'd5;

  typedef struct packed {
    logic load;    // latch the request
    logic lookup;  // register set read data and evaluate
    logic update;  // write the chosen way and the result
  } ctrl_t;

  typedef struct packed {
    logic clear_done;
  } stat_t;
endpackage

[rtl/sacc_ctrl.sv]
// Controller state machine for the cache controller.
module sacc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sacc_pkg::stat_t stat,
  output sacc_pkg::ctrl_t ctrl
);
  import sacc_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StEval = 2'd3;

  logic [1:0] state, state_next;
  logic out_pending, out_pending_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    out_pending_next = out_pending;
    if (out_pending && !out_stall) out_pending_next = 1'b0;
    in_stall = 1'b1;
    case (state)
      StClear: if (stat.clear_done) state_next = StIdle;
      StIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_next = StRead;
        end
      end
      StRead: begin
        ctrl.lookup = 1'b1;
        state_next = StEval;
      end
      StEval: begin
        // hold the evaluated access until the output register frees
        if (!out_pending || !out_stall) begin
          ctrl.update = 1'b1;
          out_pending_next = 1'b1;
          state_next = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  assign out_valid = out_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StClear;
      out_pending <= 1'b0;
    end else begin
      state <= state_next;
      out_pending <= out_pending_next;
    end
  end
endmodule

[rtl/sacc_dp.sv]
// Datapath: line memories, tag compare, victim choice and cost.
module sacc_dp #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  sacc_pkg::ctrl_t ctrl,
  output sacc_pkg::stat_t stat,
  input  logic [3:0] cfg_set_bits,
  input  logic [3:0] cfg_ways,
  input  logic [3:0] cfg_block_bits,
  input  logic cfg_write_allocate,
  input  logic cfg_write_back,
  input  logic cfg_use_lru,
  input  logic operation,
  input  logic [31:0] address,
  output logic hit,
  output logic evicted_dirty,
  output logic [sacc_pkg::CostW-1:0] cost_cycles
);
  import sacc_pkg::*;

  localparam int SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SbLim = $clog2(MAX_SETS + 1) - 1;
  localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef struct packed {
    logic valid;
    logic dirty;
    logic [31:0] tag;
    logic [31:0] stamp;
  } line_t;

  line_t mem [MAX_SETS][MAX_WAYS];
  line_t rd [MAX_WAYS];

  logic [SetW-1:0] clr_idx;
  logic clearing;
  logic req_store;
  logic [SetW-1:0] req_set;
  logic [31:0] req_tag;
  logic [31:0] access_clock;
  logic [4:0] eff_ways;
  logic [3:0] eff_sb;

  logic [31:0] addr_m;
  logic [SetW-1:0] set_c;
  logic [31:0] tag_c;

  always_comb begin
    logic [63:0] sh;
    eff_sb = (32'(cfg_set_bits) < SbLim) ? cfg_set_bits : 4'(SbLim);
    addr_m = 32'(address[AW-1:0]);
    sh = 64'(addr_m) >> cfg_block_bits;
    set_c = SetW'(sh & ((64'd1 << eff_sb) - 64'd1));
    tag_c = 32'(sh >> eff_sb);
    if (cfg_ways == 4'd0) eff_ways = 5'd1;
    else if (32'(cfg_ways) > MAX_WAYS) eff_ways = 5'(MAX_WAYS);
    else eff_ways = {1'b0, cfg_ways};
  end

  assign stat.clear_done = clearing && (clr_idx == SetW'(MAX_SETS - 1));

  // evaluation on registered set contents
  logic hit_c;
  logic [WayW-1:0] hit_w, empty_w, old_w, vic_w;
  logic have_empty;
  logic [31:0] old_stamp;
  logic alloc, fill_dirty, evd_c;
  logic [19:0] wcost;
  logic [20:0] cost_c;

  always_comb begin
    logic found;
    hit_c = 1'b0; hit_w = '0; have_empty = 1'b0; empty_w = '0;
    old_w = '0; old_stamp = '0; found = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < eff_ways) begin
        if (rd[w].valid) begin
          if (rd[w].tag == req_tag && !hit_c) begin
            hit_c = 1'b1; hit_w = WayW'(w);
          end
          if (!found || rd[w].stamp < old_stamp) begin
            old_stamp = rd[w].stamp; old_w = WayW'(w); found = 1'b1;
          end
        end else if (!have_empty) begin
          have_empty = 1'b1; empty_w = WayW'(w);
        end
      end
    end
    vic_w = have_empty ? empty_w : old_w;
    wcost = 20'(MissUnit) * ((20'd1 << cfg_block_bits) >> 2);
    cost_c = 21'd1;
    if (req_store && !cfg_write_back && cfg_write_allocate) cost_c = cost_c + 21'(MissUnit);
    alloc = 1'b0; fill_dirty = 1'b0;
    if (!hit_c) begin
      cost_c = cost_c + 21'(wcost);
      if (!req_store) alloc = 1'b1;
      else if (cfg_write_back) begin alloc = 1'b1; fill_dirty = 1'b1; end
      else alloc = cfg_write_allocate;
    end
    evd_c = alloc && !have_empty && rd[vic_w].valid && rd[vic_w].dirty;
    if (evd_c) cost_c = cost_c + 21'(wcost);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      access_clock <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SetW'(1);
        if (stat.clear_done) clearing <= 1'b0;
      end
      if (ctrl.load) access_clock <= access_clock + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        mem[clr_idx][w].valid <= 1'b0;
        mem[clr_idx][w].dirty <= 1'b0;
      end
    end
    if (ctrl.load) begin
      req_store <= operation;
      req_set <= set_c;
      req_tag <= tag_c;
    end
    if (ctrl.lookup) begin
      for (int w = 0; w < MAX_WAYS; w++) rd[w] <= mem[req_set][w];
    end
    if (ctrl.update) begin
      hit <= hit_c;
      evicted_dirty <= evd_c;
      cost_cycles <= (cost_c > 21'(CostMax)) ? CostMax : cost_c[CostW-1:0];
      if (hit_c) begin
        if (req_store && cfg_write_back) mem[req_set][hit_w].dirty <= 1'b1;
        if (cfg_use_lru) mem[req_set][hit_w].stamp <= access_clock;
      end else if (alloc) begin
        mem[req_set][vic_w] <= '{valid: 1'b1, dirty: fill_dirty,
                                 tag: req_tag, stamp: access_clock};
      end
    end
  end
endmodule

[rtl/set_assoc_cache_controller_unit.sv]
// A result is registered after the set read and the evaluate/update step.
// Accesses do not overlap: one is taken only after the latch, single-port set read and write.
// An access is taken while a result waits; it holds in evaluation until the output frees.
// Reset: synchronous; a clearing pass over all MAX_SETS sets sweeps valid and
// dirty bits, one set per cycle, before the first input transfer is taken.
module set_assoc_cache_controller_unit #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic [31:0] address,
  output logic out_valid,
  input  logic out_stall,
  output logic hit,
  output logic evicted_dirty,
  output logic [15:0] cost_cycles
);
  import sacc_pkg::*;

  logic [3:0] set_bits, ways, block_bits;
  logic write_allocate, write_back, use_lru;
  ctrl_t ctrl;
  stat_t stat;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 4'd8; ways <= 4'd4; block_bits <= 4'd4;
      write_allocate <= 1'b1; write_back <= 1'b1; use_lru <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        RegSetBits: set_bits <= pwdata[3:0];
        RegWays: ways <= pwdata[3:0];
        RegBlockBits: block_bits <= pwdata[3:0];
        RegWriteAlloc: write_allocate <= pwdata[0];
        RegWriteBack: write_back <= pwdata[0];
        RegUseLru: use_lru <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegSetBits: prdata = {28'd0, set_bits};
      RegWays: prdata = {28'd0, ways};
      RegBlockBits: prdata = {28'd0, block_bits};
      RegWriteAlloc: prdata = {31'd0, write_allocate};
      RegWriteBack: prdata = {31'd0, write_back};
      RegUseLru: prdata = {31'd0, use_lru};
      default: prdata = '0;
    endcase
  end

  sacc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .ctrl
  );

  sacc_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .ctrl, .stat,
    .cfg_set_bits(set_bits), .cfg_ways(ways), .cfg_block_bits(block_bits),
    .cfg_write_allocate(write_allocate), .cfg_write_back(write_back),
    .cfg_use_lru(use_lru),
    .operation, .address, .hit, .evicted_dirty, .cost_cycles
  );
endmodule

[tb/tb_set_assoc_cache_controller_unit.sv]
// Testbench for the set-associative cache controller: directed and random accesses checked against a built-in cache model.
`timescale 1ns / 1ps

module tb_set_assoc_cache_controller_unit;
  import sacc_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic        store;
    logic [31:0] addr;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic        evd;
    logic [15:0] cost;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [31:0] address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit, evicted_dirty;
  logic [15:0] cost_cycles;

  set_assoc_cache_controller_unit u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .address(address),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .evicted_dirty(evicted_dirty), .cost_cycles(cost_cycles)
  );

  // cache shadow state
  logic        m_valid [NSETS*NWAYS];
  logic        m_dirty [NSETS*NWAYS];
  logic [31:0] m_tag   [NSETS*NWAYS];
  logic [31:0] m_stamp [NSETS*NWAYS];
  logic [31:0] m_clock;
  logic [3:0]  c_set_bits, c_ways, c_block_bits;
  logic        c_walloc, c_wback, c_lru;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  bit hold_start = 1'b0;
  int hold_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int sb, nw, blk, set_idx, base, hit_way, empty_way, old_way, idx;
    logic [31:0] tag, old_stamp;
    logic [63:0] wcost, cost;
    bit found, alloc, fill_dirty;
    sb = (c_set_bits > 8) ? 8 : c_set_bits;
    nw = (c_ways == 0) ? 1 : ((c_ways > NWAYS) ? NWAYS : c_ways);
    blk = c_block_bits;
    set_idx = (a.addr >> blk) & ((1 << sb) - 1);
    tag = a.addr >> (blk + sb);
    wcost = 64'd100 * ((64'd1 << blk) >> 2);
    base = set_idx * NWAYS;
    m_clock = m_clock + 1;
    cost = 1;
    r = '0;
    hit_way = -1; empty_way = -1; old_way = 0; old_stamp = 0; found = 0;
    for (int w = 0; w < nw; w++) begin
      idx = base + w;
      if (m_valid[idx]) begin
        if (m_tag[idx] == tag && hit_way < 0) hit_way = w;
        if (!found || m_stamp[idx] < old_stamp) begin
          old_stamp = m_stamp[idx];
          old_way = w;
          found = 1;
        end
      end else if (empty_way < 0) begin
        empty_way = w;
      end
    end
    alloc = 0; fill_dirty = 0;
    if (a.store && !c_wback && c_walloc) cost += 100;
    if (hit_way >= 0) begin
      idx = base + hit_way;
      r.hit = 1;
      if (a.store && c_wback) m_dirty[idx] = 1;
      if (c_lru) m_stamp[idx] = m_clock;
    end else begin
      cost += wcost;
      if (!a.store) alloc = 1;
      else if (c_wback) begin
        alloc = 1;
        fill_dirty = 1;
      end else alloc = c_walloc;
    end
    if (alloc) begin
      idx = base + ((empty_way >= 0) ? empty_way : old_way);
      if (empty_way < 0 && m_valid[idx] && m_dirty[idx]) begin
        r.evd = 1;
        cost += wcost;
      end
      m_valid[idx] = 1;
      m_tag[idx] = tag;
      m_dirty[idx] = fill_dirty;
      m_stamp[idx] = m_clock;
    end
    r.cost = (cost > 65535) ? 16'hFFFF : cost[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        accepted++;
        expected_outcomes.push_back(cache_access('{store: operation, addr: address}));
      end
      if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        access_t a;
        a = pending_accesses.pop_front();
        in_valid <= 1'b1;
        operation <= a.store;
        address <= a.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        outcome_t e;
        if (expected_outcomes.size() == 0) begin
          $display("MISMATCH unexpected result transfer");
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          if (hit !== e.hit) report_mismatch("hit", 32'(hit), 32'(e.hit));
          if (evicted_dirty !== e.evd)
            report_mismatch("evicted_dirty", 32'(evicted_dirty), 32'(e.evd));
          if (cost_cycles !== e.cost)
            report_mismatch("cost_cycles", 32'(cost_cycles), 32'(e.cost));
        end
        checked++;
      end
      out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold, counted here
  always @(posedge clk) begin
    if (hold_start) begin
      hold_recv <= 1'b1;
      hold_count <= 0;
    end else if (hold_recv) begin
      hold_count <= hold_count + 1;
      if (hold_count >= HOLD_CYCLES - 1) hold_recv <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegSetBits:    c_set_bits = val[3:0];
      RegWays:       c_ways = val[3:0];
      RegBlockBits:  c_block_bits = val[3:0];
      RegWriteAlloc: c_walloc = val[0];
      RegWriteBack:  c_wback = val[0];
      RegUseLru:     c_lru = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_accesses.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(int sb, int nw, int bb, bit wa, bit wb, bit lru);
    drain();
    write_reg(RegSetBits, 32'(sb));
    write_reg(RegWays, 32'(nw));
    write_reg(RegBlockBits, 32'(bb));
    write_reg(RegWriteAlloc, 32'(wa));
    write_reg(RegWriteBack, 32'(wb));
    write_reg(RegUseLru, 32'(lru));
  endtask

  // mostly addresses from a small pool so sets refill and evict; the rest fully random
  task automatic queue_random(int n);
    logic [31:0] pool[16];
    access_t a;
    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      a.store = $urandom_range(1);
      if ($urandom_range(9) < 7)
        a.addr = (pool[$urandom_range(15)] & 32'hFFFF_0000) | ($urandom_range(7) << 4)
                 | ($urandom & 32'h0000_FF0F);
      else
        a.addr = $urandom;
      pending_accesses.push_back(a);
    end
  endtask

  initial begin
    access_t a;
    foreach (m_valid[i]) begin
      m_valid[i] = 0; m_dirty[i] = 0; m_tag[i] = 0; m_stamp[i] = 0;
    end
    m_clock = 0;
    c_set_bits = 8; c_ways = 4; c_block_bits = 4;
    c_walloc = 1; c_wback = 1; c_lru = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, conflict misses into one set, dirty evictions
    a = '{store: 1'b0, addr: 32'h0000_0000}; pending_accesses.push_back(a);
    a = '{store: 1'b1, addr: 32'hFFFF_FFFF}; pending_accesses.push_back(a);
    a = '{store: 1'b0, addr: 32'hFFFF_FFFF}; pending_accesses.push_back(a);
    for (int i = 0; i < 6; i++) begin
      a = '{store: 1'(i % 2), addr: (32'(i) << 12) | 32'h40};
      pending_accesses.push_back(a);
    end
    a = '{store: 1'b0, addr: 32'h40}; pending_accesses.push_back(a);
    a = '{store: 1'b1, addr: 32'hAAAA_5555}; pending_accesses.push_back(a);
    a = '{store: 1'b0, addr: 32'h5555_AAAA}; pending_accesses.push_back(a);

    // extremes of config, out-of-range values saturate
    configure(0, 1, 9, 0, 1, 0);
    for (int i = 0; i < 8; i++) begin
      a = '{store: 1'b1, addr: 32'(i) << 20}; pending_accesses.push_back(a);
    end
    configure(15, 15, 15, 1, 0, 1);
    queue_random(10);
    configure(8, 0, 2, 1, 0, 0);
    queue_random(10);

    // random phases across settings and idling patterns
    for (int p = 0; p < 8; p++) begin
      configure($urandom_range(8), $urandom_range(1, 8), $urandom_range(2, 9),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      queue_random(230);
      if (p == 4) begin
        // back-pressure: hold the receiver while items keep coming
        send_idle_pct = 0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        @(posedge clk);
        while (hold_recv) @(posedge clk);
      end
    end
    configure(4, 8, 2, 0, 0, 1);
    send_idle_pct = 0; recv_stall_pct = 0;
    queue_random(60);
    drain();

    $display("covered %0d accesses, %0d results checked, over 12 register settings",
             accepted, checked);
    $display("sender and receiver idling phases plus a long output hold were exercised");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/sacc_pkg.sv
rtl/sacc_ctrl.sv
rtl/sacc_dp.sv
rtl/set_assoc_cache_controller_unit.sv
tb/tb_set_assoc_cache_controller_unit.sv
